// ===== hdl/rc4_pkg.sv =====
// rc4_pkg: item types, sequencer states and sizing constants for the RC4 engine.
// No dependencies; imported by rc4_stream_cipher.
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int SBOX_DEPTH = 256;
  localparam int ADDR_W     = $clog2(SBOX_DEPTH);
  localparam int COUNT_W    = ADDR_W + 1;

  localparam logic [COUNT_W-1:0] MAX_KEY_BYTES = COUNT_W'(256);
  localparam logic [ADDR_W-1:0]  LAST_INDEX    = ADDR_W'(SBOX_DEPTH - 1);

  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] value;
    logic       last;
  } req_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       end_of_message;
    logic       no_key;
  } rsp_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD_K,
    ST_KS_RD_J,
    ST_KS_WR_K,
    ST_KS_WR_J,
    ST_D_RD_I,
    ST_D_RD_J,
    ST_D_WR_I,
    ST_D_WR_J,
    ST_D_RD_K,
    ST_D_OUT
  } seq_state_t;

endpackage

// ===== hdl/rc4_stream_cipher.sv =====
// rc4_stream_cipher: RC4 engine with key store, S-box memory and one sequencer.
// Depends on rc4_pkg.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | rc4_pkg::req_item_t (mode, value, last)
//   rsp     | out       | rsp_valid / rsp_stall | rc4_pkg::rsp_item_t (data, eom, no_key)
//
// Key item: stored while idle; with last, S-box fill, then ST_KS_* rounds. Data item:
// ST_D_* steps if keyed, else ST_D_OUT; the single S-box write port sets both loops.
// Reset (rst, synchronous) clears indices, key count and keyed; memories are not cleared.
// A finished item waits in the output register while rsp_stall is high; the sequencer
// holds in its last step until that register is free.
`timescale 1ns / 1ps

module rc4_stream_cipher (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  rc4_pkg::req_item_t   req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rc4_pkg::rsp_item_t   rsp
);
  import rc4_pkg::*;

  logic [7:0] sbox      [SBOX_DEPTH];
  logic [7:0] key_store [SBOX_DEPTH];
  logic [7:0] s_rdata;
  logic [7:0] k_rdata;

  seq_state_t         state, state_next;
  logic [ADDR_W-1:0]  cnt, cnt_next;
  logic [ADDR_W-1:0]  kidx, kidx_next;
  logic [ADDR_W-1:0]  index_i, index_i_next;
  logic [ADDR_W-1:0]  index_j, index_j_next;
  logic [COUNT_W-1:0] key_count, key_count_next;
  logic               keyed, keyed_next;
  logic               rsp_valid_next;
  logic [7:0]         hold1, hold1_next;
  logic [7:0]         hold2, hold2_next;
  logic [7:0]         val, val_next;
  logic               lst, lst_next;
  logic               nokey, nokey_next;
  rsp_item_t          rsp_next;

  logic               s_we;
  logic [ADDR_W-1:0]  s_waddr;
  logic [7:0]         s_wdata;
  logic [ADDR_W-1:0]  s_raddr;
  logic               k_we;
  logic               req_take;
  logic               rsp_free;
  logic [ADDR_W-1:0]  j_sum;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (s_we) begin
      sbox[s_waddr] <= s_wdata;
    end
    s_rdata <= sbox[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (k_we) begin
      key_store[key_count[ADDR_W-1:0]] <= req.value;
    end
    k_rdata <= key_store[kidx];
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    kidx_next      = kidx;
    index_i_next   = index_i;
    index_j_next   = index_j;
    key_count_next = key_count;
    keyed_next     = keyed;
    rsp_valid_next = rsp_valid && rsp_stall;
    hold1_next     = hold1;
    hold2_next     = hold2;
    val_next       = val;
    lst_next       = lst;
    nokey_next     = nokey;
    rsp_next       = rsp;
    s_we           = 1'b0;
    s_waddr        = cnt;
    s_wdata        = cnt;
    s_raddr        = cnt;
    k_we           = 1'b0;
    j_sum          = index_j + s_rdata;

    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          if (req.mode == MODE_KEY) begin
            if (key_count < MAX_KEY_BYTES) begin
              k_we           = 1'b1;
              key_count_next = key_count + COUNT_W'(1);
            end
            if (req.last) begin
              cnt_next   = '0;
              state_next = ST_INIT;
            end
          end else begin
            val_next   = req.value;
            lst_next   = req.last;
            nokey_next = !keyed;
            state_next = keyed ? ST_D_RD_I : ST_D_OUT;
          end
        end
      end
      ST_INIT: begin
        s_we     = 1'b1;
        cnt_next = cnt + ADDR_W'(1);
        if (cnt == LAST_INDEX) begin
          kidx_next    = '0;
          index_j_next = '0;
          state_next   = ST_KS_RD_K;
        end
      end
      ST_KS_RD_K: begin
        s_raddr    = cnt;
        state_next = ST_KS_RD_J;
      end
      ST_KS_RD_J: begin
        j_sum        = index_j + s_rdata + k_rdata;
        hold1_next   = s_rdata;
        index_j_next = j_sum;
        s_raddr      = j_sum;
        state_next   = ST_KS_WR_K;
      end
      ST_KS_WR_K: begin
        s_we       = 1'b1;
        s_waddr    = cnt;
        s_wdata    = s_rdata;
        state_next = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        s_we    = 1'b1;
        s_waddr = index_j;
        s_wdata = hold1;
        if ({1'b0, kidx} + COUNT_W'(1) >= key_count) begin
          kidx_next = '0;
        end else begin
          kidx_next = kidx + ADDR_W'(1);
        end
        cnt_next = cnt + ADDR_W'(1);
        if (cnt == LAST_INDEX) begin
          index_i_next   = '0;
          index_j_next   = '0;
          key_count_next = '0;
          keyed_next     = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          state_next = ST_KS_RD_K;
        end
      end
      ST_D_RD_I: begin
        index_i_next = index_i + ADDR_W'(1);
        s_raddr      = index_i + ADDR_W'(1);
        state_next   = ST_D_RD_J;
      end
      ST_D_RD_J: begin
        hold1_next   = s_rdata;
        index_j_next = j_sum;
        s_raddr      = j_sum;
        state_next   = ST_D_WR_I;
      end
      ST_D_WR_I: begin
        s_we       = 1'b1;
        s_waddr    = index_i;
        s_wdata    = s_rdata;
        hold2_next = s_rdata;
        state_next = ST_D_WR_J;
      end
      ST_D_WR_J: begin
        s_we       = 1'b1;
        s_waddr    = index_j;
        s_wdata    = hold1;
        state_next = ST_D_RD_K;
      end
      ST_D_RD_K: begin
        s_raddr    = hold1 + hold2;
        state_next = ST_D_OUT;
      end
      ST_D_OUT: begin
        s_raddr = hold1 + hold2;
        if (rsp_free) begin
          rsp_valid_next          = 1'b1;
          rsp_next.data           = nokey ? val : (val ^ s_rdata);
          rsp_next.end_of_message = lst;
          rsp_next.no_key         = nokey;
          state_next              = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      kidx      <= '0;
      index_i   <= '0;
      index_j   <= '0;
      key_count <= '0;
      keyed     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      kidx      <= kidx_next;
      index_i   <= index_i_next;
      index_j   <= index_j_next;
      key_count <= key_count_next;
      keyed     <= keyed_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    hold1 <= hold1_next;
    hold2 <= hold2_next;
    val   <= val_next;
    lst   <= lst_next;
    nokey <= nokey_next;
    rsp   <= rsp_next;
  end

endmodule
